### src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion macros for the terrain height unit.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define OPT_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked out of reset.
`define OPT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### src/opt_pkg.sv
// ----------------------------------------------------------------------------
// opt_pkg
// Types and constants shared by the terrain height controller and datapath.
// ----------------------------------------------------------------------------
package opt_pkg;

  // Permutation table geometry
  localparam int TBL_AW = 8;

  // Shuffle seed used after reset
  localparam logic [7:0] DEFAULT_SEED = 8'd42;

  // Controller states
  typedef enum logic [4:0] {
    ST_SEED,
    ST_FILL,
    ST_SWAP_RD,
    ST_SWAP_WA,
    ST_SWAP_WB,
    ST_IDLE,
    ST_ADDR,
    ST_FADE1,
    ST_FADE2,
    ST_FADE3,
    ST_GRAD,
    ST_LERPX,
    ST_SUMX,
    ST_LERPY,
    ST_SUMY,
    ST_WEIGHT,
    ST_ACC,
    ST_DIV_SETUP,
    ST_DIV_STEP,
    ST_FINISH
  } opt_state_t;

  // Datapath operations
  typedef enum logic [4:0] {
    OP_NONE,
    OP_SEED,
    OP_CAPTURE,
    OP_FILL,
    OP_SWAP_RD,
    OP_SWAP_WA,
    OP_SWAP_WB,
    OP_ADDR,
    OP_FADE1,
    OP_FADE2,
    OP_FADE3,
    OP_GRAD,
    OP_LERPX,
    OP_SUMX,
    OP_LERPY,
    OP_SUMY,
    OP_WEIGHT,
    OP_ACC,
    OP_DIV_SETUP,
    OP_DIV_STEP,
    OP_FINISH
  } opt_op_t;

  typedef struct packed {
    opt_op_t op;
  } opt_cmd_t;

  typedef struct packed {
    logic fill_last;
    logic swap_last;
    logic oct_last;
    logic div_last;
  } opt_sts_t;

endpackage

### src/opt_ctrl.sv
// ----------------------------------------------------------------------------
// opt_ctrl
// Sequencer: table rebuild, per-octave steps, divide and result posting.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module opt_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_kind,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  opt_pkg::opt_sts_t sts,
  output opt_pkg::opt_cmd_t cmd
);

  opt_pkg::opt_state_t state_r, state_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                post;

  // state and result-valid registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= opt_pkg::ST_SEED;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd.op    = opt_pkg::OP_NONE;
    post      = 1'b0;
    case (state_r)
      opt_pkg::ST_SEED: begin
        cmd.op    = opt_pkg::OP_SEED;
        state_nxt = opt_pkg::ST_FILL;
      end
      opt_pkg::ST_FILL: begin
        cmd.op = opt_pkg::OP_FILL;
        if (sts.fill_last) state_nxt = opt_pkg::ST_SWAP_RD;
      end
      opt_pkg::ST_SWAP_RD: begin
        cmd.op    = opt_pkg::OP_SWAP_RD;
        state_nxt = opt_pkg::ST_SWAP_WA;
      end
      opt_pkg::ST_SWAP_WA: begin
        cmd.op    = opt_pkg::OP_SWAP_WA;
        state_nxt = opt_pkg::ST_SWAP_WB;
      end
      opt_pkg::ST_SWAP_WB: begin
        cmd.op    = opt_pkg::OP_SWAP_WB;
        state_nxt = sts.swap_last ? opt_pkg::ST_IDLE : opt_pkg::ST_SWAP_RD;
      end
      opt_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.op    = opt_pkg::OP_CAPTURE;
          state_nxt = in_kind ? opt_pkg::ST_FILL : opt_pkg::ST_ADDR;
        end
      end
      opt_pkg::ST_ADDR: begin
        cmd.op    = opt_pkg::OP_ADDR;
        state_nxt = opt_pkg::ST_FADE1;
      end
      opt_pkg::ST_FADE1: begin
        cmd.op    = opt_pkg::OP_FADE1;
        state_nxt = opt_pkg::ST_FADE2;
      end
      opt_pkg::ST_FADE2: begin
        cmd.op    = opt_pkg::OP_FADE2;
        state_nxt = opt_pkg::ST_FADE3;
      end
      opt_pkg::ST_FADE3: begin
        cmd.op    = opt_pkg::OP_FADE3;
        state_nxt = opt_pkg::ST_GRAD;
      end
      opt_pkg::ST_GRAD: begin
        cmd.op    = opt_pkg::OP_GRAD;
        state_nxt = opt_pkg::ST_LERPX;
      end
      opt_pkg::ST_LERPX: begin
        cmd.op    = opt_pkg::OP_LERPX;
        state_nxt = opt_pkg::ST_SUMX;
      end
      opt_pkg::ST_SUMX: begin
        cmd.op    = opt_pkg::OP_SUMX;
        state_nxt = opt_pkg::ST_LERPY;
      end
      opt_pkg::ST_LERPY: begin
        cmd.op    = opt_pkg::OP_LERPY;
        state_nxt = opt_pkg::ST_SUMY;
      end
      opt_pkg::ST_SUMY: begin
        cmd.op    = opt_pkg::OP_SUMY;
        state_nxt = opt_pkg::ST_WEIGHT;
      end
      opt_pkg::ST_WEIGHT: begin
        cmd.op    = opt_pkg::OP_WEIGHT;
        state_nxt = opt_pkg::ST_ACC;
      end
      opt_pkg::ST_ACC: begin
        cmd.op    = opt_pkg::OP_ACC;
        state_nxt = sts.oct_last ? opt_pkg::ST_DIV_SETUP : opt_pkg::ST_ADDR;
      end
      opt_pkg::ST_DIV_SETUP: begin
        cmd.op    = opt_pkg::OP_DIV_SETUP;
        state_nxt = opt_pkg::ST_DIV_STEP;
      end
      opt_pkg::ST_DIV_STEP: begin
        cmd.op = opt_pkg::OP_DIV_STEP;
        if (sts.div_last) state_nxt = opt_pkg::ST_FINISH;
      end
      opt_pkg::ST_FINISH: begin
        // wait for the output register to free up
        if (!out_valid_r || !out_stall) begin
          cmd.op    = opt_pkg::OP_FINISH;
          post      = 1'b1;
          state_nxt = opt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = opt_pkg::ST_IDLE;
      end
    endcase
  end

  // result beat stays until taken
  always_comb begin
    if (post) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign in_stall  = (state_r != opt_pkg::ST_IDLE);
  assign out_valid = out_valid_r;

  `OPT_ASSERT_NEXT(a_build_to_idle, clk, rst_n, state_r == opt_pkg::ST_SWAP_WB && sts.swap_last, state_r == opt_pkg::ST_IDLE)
  `OPT_ASSERT_NEXT(a_result_posted, clk, rst_n, state_r == opt_pkg::ST_FINISH && (!out_valid_r || !out_stall), out_valid_r)
  `OPT_ASSERT_NEXT(a_octave_loop, clk, rst_n, state_r == opt_pkg::ST_ACC && !sts.oct_last, state_r == opt_pkg::ST_ADDR)

endmodule

### src/opt_dp.sv
// ----------------------------------------------------------------------------
// opt_dp
// Datapath: permutation table, fade and lerp multipliers, octave
// accumulators, restoring divider and class lookup.
// ----------------------------------------------------------------------------
module opt_dp #(
  parameter int MAX_OCTAVES = 8
) (
  input  logic              clk,
  input  opt_pkg::opt_cmd_t cmd,
  output opt_pkg::opt_sts_t sts,
  input  logic [31:0]       in_coord_x,
  input  logic [31:0]       in_coord_y,
  input  logic [30:0]       in_seed,
  input  logic [3:0]        octave_count,
  input  logic [15:0]       persistence,
  output logic [15:0]       out_height,
  output logic [2:0]        out_terrain_class
);

  localparam int KW    = $clog2(MAX_OCTAVES + 1);
  localparam int LW    = 21;                         // lerp / noise values
  localparam int PW    = LW + 18;                    // noise * amplitude
  localparam int TOT_W = PW + $clog2(MAX_OCTAVES) + 1;
  localparam int AS_W  = 18 + $clog2(MAX_OCTAVES);
  localparam int NUM_W = TOT_W + 1;
  localparam int RW    = NUM_W - 1;

  localparam logic [19:0] FADE_A   = 20'd983040;
  localparam logic [19:0] FADE_B   = 20'd655360;
  localparam logic [16:0] AMP_ONE  = 17'd65536;
  localparam logic [7:0]  SEED_MUL = 8'd13;   // low byte of the LCG multiplier
  localparam logic [7:0]  SEED_INC = 8'd95;   // low byte of the LCG increment
  localparam logic [15:0] CLASS_LIMIT [7] = '{
    16'd19661, 16'd24904, 16'd27526, 16'd39322, 16'd47186, 16'd53740, 16'd60294
  };

  // permutation table
  logic [7:0] mem [2**opt_pkg::TBL_AW];
  logic [7:0] rd_a_r, rd_b_r;
  logic [7:0] rd_addr_a, rd_addr_b, wr_addr, wr_data;
  logic       rd_en, wr_en;

  // shuffle and sample state
  logic [7:0]         seed_r, idx_r, swap_j;
  logic signed [31:0] cx_r, cy_r;
  logic [KW-1:0]      k_r, n_eff;
  logic [15:0]        fx_r, fy_r;
  logic [7:0]         xi_r, yi_r, pb_r, haa_r, hab_r;
  logic [31:0]        sqx_r, sqy_r;
  logic [35:0]        linx_r, liny_r;
  logic [15:0]        cubex_r, cubey_r;
  logic [19:0]        innerx_r, innery_r;
  logic [16:0]        u_r, v_r;
  logic signed [18:0] gaa_r, gba_r, gab_r, gbb_r;
  logic signed [37:0] plo_r, phi_r;
  logic signed [LW-1:0] lo_r, hi_r, nz_r;
  logic signed [39:0] pv_r;
  logic signed [PW-1:0] pw_r;
  logic [32:0]        pamp_r;
  logic [16:0]        amp_r;
  logic signed [TOT_W-1:0] total_r;
  logic [AS_W-1:0]    ampsum_r;
  logic [RW-1:0]      rem_r, dsh_r;
  logic [15:0]        q_r;
  logic [3:0]         dcnt_r;
  logic               sat_r;
  logic [15:0]        out_height_r;
  logic [2:0]         out_class_r;

  // combinational helpers
  logic [31:0]        xs, ys;
  logic [19:0]        mulx, muly;
  logic [47:0]        cubx_full, cuby_full;
  logic [35:0]        fadx_full, fady_full;
  logic signed [17:0] dx0, dx1, dy0, dy1, us, vs;
  logic signed [19:0] dlo, dhi;
  logic signed [21:0] dv;
  logic signed [NUM_W-1:0] num;
  logic [15:0]        h_fin;
  logic [2:0]         cls_fin;

  function automatic logic signed [18:0] grad(input logic [1:0] h,
                                              input logic signed [17:0] dx,
                                              input logic signed [17:0] dy);
    logic signed [18:0] g;
    case (h)
      2'd0:    g = 19'(dx) + 19'(dy);
      2'd3:    g = -(19'(dx)) - 19'(dy);
      default: g = 19'(dy) - 19'(dx);
    endcase
    return g;
  endfunction

  assign swap_j = seed_r * SEED_MUL + idx_r * SEED_INC;

  // octave point: cell index and fraction
  assign xs = cx_r << k_r;
  assign ys = cy_r << k_r;

  // fade terms
  assign mulx      = FADE_A - 20'(fx_r) * 20'd6;
  assign muly      = FADE_A - 20'(fy_r) * 20'd6;
  assign cubx_full = 48'(sqx_r) * 48'(fx_r);
  assign cuby_full = 48'(sqy_r) * 48'(fy_r);
  assign fadx_full = 36'(cubex_r) * 36'(innerx_r);
  assign fady_full = 36'(cubey_r) * 36'(innery_r);

  // corner offsets
  assign dx0 = $signed({2'b00, fx_r});
  assign dy0 = $signed({2'b00, fy_r});
  assign dx1 = dx0 - 18'sh10000;
  assign dy1 = dy0 - 18'sh10000;
  assign us  = $signed({1'b0, u_r});
  assign vs  = $signed({1'b0, v_r});
  assign dlo = 20'(gba_r) - 20'(gaa_r);
  assign dhi = 20'(gbb_r) - 20'(gab_r);
  assign dv  = 22'(hi_r) - 22'(lo_r);

  // normalization numerator
  assign num = NUM_W'(total_r) + $signed(NUM_W'({ampsum_r, 16'b0}));

  // octave count clamp
  always_comb begin
    if (octave_count == '0) begin
      n_eff = KW'(1);
    end else if (int'(octave_count) > MAX_OCTAVES) begin
      n_eff = KW'(MAX_OCTAVES);
    end else begin
      n_eff = KW'(octave_count);
    end
  end

  // final height and class
  always_comb begin
    h_fin   = sat_r ? 16'hFFFF : q_r;
    cls_fin = 3'd7;
    for (int c = 6; c >= 0; c--) begin
      if (h_fin < CLASS_LIMIT[c]) cls_fin = 3'(c);
    end
  end

  // table port control
  always_comb begin
    rd_en     = 1'b0;
    wr_en     = 1'b0;
    rd_addr_a = idx_r;
    rd_addr_b = swap_j;
    wr_addr   = idx_r;
    wr_data   = idx_r;
    case (cmd.op)
      opt_pkg::OP_FILL: begin
        wr_en = 1'b1;
      end
      opt_pkg::OP_SWAP_RD: begin
        rd_en = 1'b1;
      end
      opt_pkg::OP_SWAP_WA: begin
        wr_en   = 1'b1;
        wr_data = rd_b_r;
      end
      opt_pkg::OP_SWAP_WB: begin
        wr_en   = 1'b1;
        wr_addr = swap_j;
        wr_data = rd_a_r;
      end
      opt_pkg::OP_FADE1: begin
        rd_en     = 1'b1;
        rd_addr_a = xi_r;
        rd_addr_b = xi_r + 8'd1;
      end
      opt_pkg::OP_FADE2: begin
        rd_en     = 1'b1;
        rd_addr_a = rd_a_r + yi_r;
        rd_addr_b = rd_a_r + yi_r + 8'd1;
      end
      opt_pkg::OP_FADE3: begin
        rd_en     = 1'b1;
        rd_addr_a = pb_r + yi_r;
        rd_addr_b = pb_r + yi_r + 8'd1;
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  // table memory
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) begin
      rd_a_r <= mem[rd_addr_a];
      rd_b_r <= mem[rd_addr_b];
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      opt_pkg::OP_SEED: begin
        seed_r <= opt_pkg::DEFAULT_SEED;
        idx_r  <= 8'hFF;
      end
      opt_pkg::OP_CAPTURE: begin
        seed_r   <= in_seed[7:0];
        idx_r    <= 8'hFF;
        cx_r     <= in_coord_x;
        cy_r     <= in_coord_y;
        k_r      <= '0;
        amp_r    <= AMP_ONE;
        total_r  <= '0;
        ampsum_r <= '0;
      end
      opt_pkg::OP_FILL, opt_pkg::OP_SWAP_WB: begin
        idx_r <= idx_r - 8'd1;
      end
      opt_pkg::OP_ADDR: begin
        fx_r <= xs[15:0];
        fy_r <= ys[15:0];
        xi_r <= xs[23:16];
        yi_r <= ys[23:16];
      end
      opt_pkg::OP_FADE1: begin
        sqx_r  <= 32'(fx_r) * 32'(fx_r);
        sqy_r  <= 32'(fy_r) * 32'(fy_r);
        linx_r <= 36'(fx_r) * 36'(mulx);
        liny_r <= 36'(fy_r) * 36'(muly);
      end
      opt_pkg::OP_FADE2: begin
        pb_r     <= rd_b_r;
        cubex_r  <= cubx_full[47:32];
        cubey_r  <= cuby_full[47:32];
        innerx_r <= FADE_B - linx_r[35:16];
        innery_r <= FADE_B - liny_r[35:16];
      end
      opt_pkg::OP_FADE3: begin
        haa_r <= rd_a_r;
        hab_r <= rd_b_r;
        u_r   <= fadx_full[32:16];
        v_r   <= fady_full[32:16];
      end
      opt_pkg::OP_GRAD: begin
        gaa_r <= grad(haa_r[1:0], dx0, dy0);
        gba_r <= grad(rd_a_r[1:0], dx1, dy0);
        gab_r <= grad(hab_r[1:0], dx0, dy1);
        gbb_r <= grad(rd_b_r[1:0], dx1, dy1);
      end
      opt_pkg::OP_LERPX: begin
        plo_r <= 38'(us) * 38'(dlo);
        phi_r <= 38'(us) * 38'(dhi);
      end
      opt_pkg::OP_SUMX: begin
        lo_r <= LW'(gaa_r) + LW'(plo_r >>> 16);
        hi_r <= LW'(gab_r) + LW'(phi_r >>> 16);
      end
      opt_pkg::OP_LERPY: begin
        pv_r <= 40'(vs) * 40'(dv);
      end
      opt_pkg::OP_SUMY: begin
        nz_r <= lo_r + LW'(pv_r >>> 16);
      end
      opt_pkg::OP_WEIGHT: begin
        pw_r   <= PW'(nz_r) * PW'($signed({1'b0, amp_r}));
        pamp_r <= 33'(amp_r) * 33'(persistence);
      end
      opt_pkg::OP_ACC: begin
        total_r  <= total_r + TOT_W'(pw_r);
        ampsum_r <= ampsum_r + AS_W'(amp_r);
        amp_r    <= pamp_r[32:16];
        k_r      <= k_r + KW'(1);
      end
      opt_pkg::OP_DIV_SETUP: begin
        // negative numerator gives zero height
        rem_r  <= num[NUM_W-1] ? '0 : num[RW-1:0];
        dsh_r  <= RW'({ampsum_r, 16'b0});
        sat_r  <= !num[NUM_W-1] && (num[RW-1:0] >= RW'({ampsum_r, 17'b0}));
        q_r    <= '0;
        dcnt_r <= 4'd15;
      end
      opt_pkg::OP_DIV_STEP: begin
        if (rem_r >= dsh_r) begin
          rem_r <= rem_r - dsh_r;
          q_r   <= {q_r[14:0], 1'b1};
        end else begin
          q_r <= {q_r[14:0], 1'b0};
        end
        dsh_r  <= dsh_r >> 1;
        dcnt_r <= dcnt_r - 4'd1;
      end
      opt_pkg::OP_FINISH: begin
        out_height_r <= h_fin;
        out_class_r  <= cls_fin;
      end
      default: begin
        seed_r <= seed_r;
      end
    endcase
  end

  // status to the sequencer
  assign sts.fill_last = (idx_r == 8'd0);
  assign sts.swap_last = (idx_r == 8'd1);
  assign sts.oct_last  = (k_r == n_eff - KW'(1));
  assign sts.div_last  = (dcnt_r == 4'd0);

  assign out_height        = out_height_r;
  assign out_terrain_class = out_class_r;

endmodule

### src/octave_perlin_terrain_height_unit.sv
// ----------------------------------------------------------------------------
// octave_perlin_terrain_height_unit
// Multi-octave 2D gradient noise height and terrain class per sample point.
// ----------------------------------------------------------------------------
// A sample beat runs N octaves and then the divide before it raises out_valid,
// where N is the octave count clamped to 1..MAX_OCTAVES (six at reset): each
// octave runs eleven steps through the shared fade, lerp and weighting
// multipliers and the two-port permutation table, and the normalization is a
// 16-step restoring divider. A rebuild beat returns no result and keeps the
// input stalled while the table is refilled and shuffled, each swap a read
// and two writes over its single write port; the same rebuild with seed 42
// runs after reset. A finished result waits in the output register while the
// next beat is taken.
module octave_perlin_terrain_height_unit #(
  parameter int MAX_OCTAVES = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_kind,
  input  logic [31:0] in_coord_x,
  input  logic [31:0] in_coord_y,
  input  logic [30:0] in_seed,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_height,
  output logic [2:0]  out_terrain_class,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic REG_OCTAVE_COUNT = 1'b0;
  localparam logic REG_PERSISTENCE  = 1'b1;

  logic [3:0]        octave_count_r;
  logic [15:0]       persistence_r;
  logic              cfg_write;
  opt_pkg::opt_cmd_t cmd;
  opt_pkg::opt_sts_t sts;

  // configuration registers
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      octave_count_r <= 4'd6;
      persistence_r  <= 16'd32768;
    end else if (cfg_write) begin
      if (paddr[2] == REG_OCTAVE_COUNT) octave_count_r <= pwdata[3:0];
      if (paddr[2] == REG_PERSISTENCE)  persistence_r  <= pwdata[15:0];
    end
  end

  assign prdata = (paddr[2] == REG_OCTAVE_COUNT) ? {28'd0, octave_count_r}
                                                 : {16'd0, persistence_r};

  // sequencer
  opt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_kind   (in_kind),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // datapath
  opt_dp #(
    .MAX_OCTAVES (MAX_OCTAVES)
  ) u_dp (
    .clk               (clk),
    .cmd               (cmd),
    .sts               (sts),
    .in_coord_x        (in_coord_x),
    .in_coord_y        (in_coord_y),
    .in_seed           (in_seed),
    .octave_count      (octave_count_r),
    .persistence       (persistence_r),
    .out_height        (out_height),
    .out_terrain_class (out_terrain_class)
  );

endmodule
